// ===== hw/rtl/iwr_pkg.sv =====
package iwr_pkg;

    // Default alphabet size and fixed field widths
    localparam int unsigned ALPHABET_SIZE_DEF = 26;
    localparam int unsigned LETTER_W          = 5;
    localparam int unsigned RANK_W            = 26;
    localparam int unsigned TAB_N             = 32;

    // Input transaction: one letter of a word
    typedef struct packed {
        logic [LETTER_W-1:0] letter;
        logic [LETTER_W-1:0] word_length;
        logic                last_letter;
    } t_in_item;

    // Output transaction: rank of a finished word
    typedef struct packed {
        logic [RANK_W-1:0] rank;
        logic              valid_res;
    } t_out_item;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic add;
        logic finish;
    } t_iwr_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic more;
        logic last;
    } t_iwr_status;

    // One row or column of binomials, indexed by a 5-bit value
    typedef logic [TAB_N-1:0][RANK_W-1:0] t_binom_row;
    typedef t_binom_row [TAB_N-1:0]       t_binom_tab;

    // Pascal table stored by k, then n: entry [k][n] holds C(n,k), zero for k > n.
    // Entries above n = 26 stay zero and are never addressed by a valid word.
    function automatic t_binom_tab build_binom_by_k();
        t_binom_tab tab;
        tab = '0;
        for (int n = 0; n <= 26; n++) begin
            tab[0][n] = RANK_W'(1);
            for (int k = 1; k <= n; k++) begin
                tab[k][n] = tab[k-1][n-1] + tab[k][n-1];
            end
        end
        return tab;
    endfunction

    localparam t_binom_tab BINOM_K = build_binom_by_k();

    // Count of all shorter words: entry [len] = sum of C(alpha,k) for k = 1 .. len-1
    function automatic t_binom_row build_prefix(int unsigned alpha);
        t_binom_row row;
        row = '0;
        for (int len = 2; len < TAB_N; len++) begin
            row[len] = row[len-1] + BINOM_K[len-1][alpha];
        end
        return row;
    endfunction

endpackage

// ===== hw/rtl/iwr_ctrl.sv =====
module iwr_ctrl
    import iwr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    input  t_iwr_status i_status,
    output t_iwr_cmd    o_cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SUM  = 1'b1;

    logic r_state, n_state;
    logic r_out_valid, n_out_valid;
    logic out_free;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;

    // Sequence: take a letter, add one term per cycle, then close the letter
    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_SUM;
                end
            end
            ST_SUM: begin
                if (i_status.more) begin
                    o_cmd.add = 1'b1;
                end else if (!i_status.last) begin
                    n_state = ST_IDLE;
                end else if (out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Hold the result until the output transaction completes
    always_comb begin
        n_out_valid = r_out_valid;
        if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
        if (o_cmd.finish) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ===== hw/rtl/iwr_datapath.sv =====
module iwr_datapath
    import iwr_pkg::*;
#(
    parameter int unsigned ALPHABET_SIZE = ALPHABET_SIZE_DEF
)
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_in_item    i_in_data,
    input  t_iwr_cmd    i_cmd,
    output t_iwr_status o_status,
    output t_out_item   o_out_data
);

    localparam logic [LETTER_W-1:0] ALPHA    = LETTER_W'(ALPHABET_SIZE);
    localparam logic [LETTER_W-1:0] ALPHA_M1 = LETTER_W'(ALPHABET_SIZE - 1);
    localparam logic [LETTER_W-1:0] POS_MAX  = '1;
    localparam t_binom_row          PREFIX   = build_prefix(ALPHABET_SIZE);

    // Word state
    logic [RANK_W-1:0]   r_rank;
    logic [LETTER_W-1:0] r_prev;
    logic [LETTER_W-1:0] r_pos;
    logic [LETTER_W-1:0] r_wlen;
    logic                r_ok;
    logic                r_last;
    // Per-letter iteration state
    logic [LETTER_W-1:0] r_ch;
    logic [LETTER_W-1:0] r_letter;
    t_binom_row          r_col;
    t_out_item           r_out;

    logic                first;
    logic                len_ok;
    logic [LETTER_W-1:0] wlen_eff;
    logic [LETTER_W-1:0] rem;
    logic [LETTER_W-1:0] first_cand;
    logic [RANK_W-1:0]   rank_base;
    logic                ok_load;
    logic                fin_ok;
    logic [LETTER_W-1:0] n_idx;

    // Checks on the incoming letter
    always_comb begin
        first      = (r_pos == '0);
        len_ok     = (i_in_data.word_length != '0) && (i_in_data.word_length <= ALPHA);
        wlen_eff   = first ? i_in_data.word_length : r_wlen;
        rem        = wlen_eff - r_pos - LETTER_W'(1);
        first_cand = first ? '0 : r_prev + LETTER_W'(1);
        if (first) begin
            ok_load   = len_ok;
            rank_base = len_ok ? PREFIX[i_in_data.word_length] : '0;
        end else begin
            ok_load   = r_ok && (i_in_data.word_length == r_wlen)
                        && (i_in_data.letter > r_prev);
            rank_base = r_rank;
        end
        ok_load = ok_load && (i_in_data.letter < ALPHA) && (r_pos < wlen_eff);
    end

    assign n_idx         = ALPHA_M1 - r_ch;
    assign fin_ok        = r_ok && (r_pos == r_wlen);
    assign o_status.more = r_ok && (r_ch < r_letter);
    assign o_status.last = r_last;
    assign o_out_data    = r_out;

    // Control state of the word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_ok  <= 1'b1;
        end else if (i_cmd.load) begin
            r_pos <= (r_pos == POS_MAX) ? POS_MAX : r_pos + LETTER_W'(1);
            r_ok  <= ok_load;
        end else if (i_cmd.finish) begin
            r_pos <= '0;
            r_ok  <= 1'b1;
        end
    end

    // Running rank and candidate sweep
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rank   <= rank_base;
            r_prev   <= i_in_data.letter;
            r_wlen   <= wlen_eff;
            r_last   <= i_in_data.last_letter;
            r_ch     <= first_cand;
            r_letter <= i_in_data.letter;
            r_col    <= BINOM_K[rem];
        end else if (i_cmd.add) begin
            r_rank <= r_rank + r_col[n_idx];
            r_ch   <= r_ch + LETTER_W'(1);
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out.rank      <= fin_ok ? r_rank + RANK_W'(1) : '0;
            r_out.valid_res <= fin_ok;
        end
    end

endmodule

// ===== hw/rtl/increasing_word_rank.sv =====
// Channel   Direction  Handshake               Payload
// in        input      i_in_valid / o_in_stall   t_in_item  (letter, word_length, last_letter)
// out       output     o_out_valid / i_out_stall t_out_item (rank, valid_res)
//
// Each letter is checked and loaded, then one binomial term per skipped candidate
// letter (0 to 25) is added through the single rank adder, then the letter is closed.
// A bad letter, and any letter after one in the word, adds no terms.
// Reset (synchronous, active low) clears the position, error flag, state and output valid.
// A finished rank waits in the output register; the next letter is taken meanwhile,
// and only a last letter holds in its closing cycle while the output is stalled.
module increasing_word_rank
    import iwr_pkg::*;
#(
    parameter int unsigned ALPHABET_SIZE = ALPHABET_SIZE_DEF
)
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    t_iwr_cmd    cmd;
    t_iwr_status status;

    // Sequencer
    iwr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // Rank arithmetic and word state
    iwr_datapath #(
        .ALPHABET_SIZE (ALPHABET_SIZE)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_data  (i_in_data),
        .i_cmd      (cmd),
        .o_status   (status),
        .o_out_data (o_out_data)
    );

endmodule
